/* hw/rtl/gke_pkg.sv */
`timescale 1ns / 1ps
package gke_pkg;

  localparam int unsigned StoreDepthDef = 1024;
  localparam int unsigned CfgAddrW      = 3;
  localparam logic [10:0] MaxObsReset   = 11'd600;
  localparam logic        RegMaxObs     = 1'b0;

  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 66;
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = 50;
  localparam int unsigned DivStepW = 7;

  localparam logic [ProdW-1:0]   Q24One        = ProdW'(64'd16777216);
  localparam logic [MulW-1:0]    NineTenthsQ24 = 33'd15099494;
  localparam logic [DivDenW-1:0] Ln2Q32        = 50'd2977044472;
  localparam logic [MulW-1:0]    InvSqrt2PiQ32 = 33'd1713444100;
  localparam logic [3:0]         TaylorTerms   = 4'd12;

  typedef enum logic {
    OpInsert = 1'b0,
    OpEval   = 1'b1
  } op_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        density_out;
    logic [31:0]        bandwidth_out;
    logic signed [31:0] mean_out;
    logic [10:0]        sample_count;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [DivStepW-1:0] steps;
    logic [DivNumW-1:0]  num;
    logic [DivDenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [5:0] {
    StIdle, StInsChk, StHvRd, StHvDat, StHvAcc, StApp, StAppAcc,
    StMeanGo, StMeanWait, StEx2Go, StEx2Wait, StM2, StVar, StSqrt,
    StRt1, StRt2, StRt3, StRt4, StRt5, StBw1, StBw2, StBw3,
    StEvChk, StEvRd, StEvDat, StEvU, StEvT, StEvQ,
    StK1, StK2, StK3, StK4, StPhi, StEvAcc,
    StFin1, StFin2, StFin3, StDone
  } state_e;

  function automatic logic [32:0] abs33(logic [31:0] v);
    logic [32:0] e;
    e = {v[31], v};
    return v[31] ? (33'd0 - e) : e;
  endfunction

  // floor(2^32 / k)
  function automatic logic [32:0] recip_q32(logic [3:0] k);
    logic [32:0] r;
    unique case (k)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/gke_store.sv */
`timescale 1ns / 1ps
module gke_store #(
  parameter int unsigned Depth = gke_pkg::StoreDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/gke_mul.sv */
`timescale 1ns / 1ps
module gke_mul (
  input  logic                      clk_i,
  input  logic [gke_pkg::MulW-1:0]  a_i,
  input  logic [gke_pkg::MulW-1:0]  b_i,
  output logic [gke_pkg::ProdW-1:0] p_o
);
  import gke_pkg::*;

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/gke_div.sv */
`timescale 1ns / 1ps
module gke_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gke_pkg::div_req_t req_i,
  output gke_pkg::div_rsp_t rsp_o
);
  import gke_pkg::*;

  logic [DivStepW-1:0] cnt_q, cnt_d;
  logic [DivDenW:0]    rem_q, rem_d;
  logic [DivNumW-1:0]  quo_q, quo_d;
  logic [DivNumW-1:0]  num_q, num_d;
  logic [DivDenW-1:0]  den_q, den_d;
  logic [DivDenW:0]    rem_sh;
  logic                ge;

  always_comb begin
    rem_sh = {rem_q[DivDenW-1:0], num_q[DivNumW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    num_d  = num_q;
    den_d  = den_q;
    if (req_i.start) begin
      cnt_d = req_i.steps;
      rem_d = '0;
      quo_d = '0;
      num_d = req_i.num;
      den_d = req_i.den;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - DivStepW'(1);
      rem_d = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[DivNumW-2:0], ge};
      num_d = {num_q[DivNumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = cnt_q != '0;
  assign rsp_o.quo  = quo_q;

endmodule

/* hw/rtl/gaussian_kde_estimator.sv */
`timescale 1ns / 1ps
// Gaussian kernel density estimator over a bounded sample store.
// Input channel (in_valid_i/in_ready_o, in_data_i): operation 0 inserts
// value as a sample, operation 1 evaluates the density at value. Every
// transaction yields one result on the output channel (out_valid_o,
// out_ready_i, out_data_o) with density, bandwidth, mean and count.
// One item is processed at a time; in_ready_o is high only while idle.
// An insert runs the halving passes, then the mean, variance, square root,
// root search and bandwidth, all on one registered multiplier and one
// radix-2 divider. An evaluate runs, for each stored sample inside the 7h
// cutoff, the divider for the scaled distance, six compare and subtract
// steps for the exponent reduction and 12 Taylor terms on the multiplier;
// a sample outside the cutoff is skipped. The final normalization follows.
// The result sits in an output register; while the receiver stalls the
// block returns to idle and takes the next transaction, but finishes it
// only once the held result is taken.
// Reset empties the store, clears sums and bandwidth and sets the limit
// register (APB, address 0) to 600.
module gaussian_kde_estimator #(
  parameter int unsigned StoreDepth = gke_pkg::StoreDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gke_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gke_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gke_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import gke_pkg::*;

  localparam int unsigned AddrW = $clog2(StoreDepth);
  localparam int unsigned CntW  = $clog2(StoreDepth + 1);

  state_e             state_q, state_d;
  in_item_t           in_q, in_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    half_q, half_d;
  logic signed [47:0] sum_q, sum_d;
  logic [63:0]        sqsum_q, sqsum_d;
  logic [31:0]        width_q, width_d;
  logic [31:0]        mean_q, mean_d;
  logic [10:0]        maxobs_q;
  logic [63:0]        ex2_q, ex2_d;
  logic [63:0]        rad_q, rad_d;
  logic [63:0]        res_q, res_d;
  logic [63:0]        bit_q, bit_d;
  logic [31:0]        sigma_q, sigma_d;
  logic [24:0]        r_q, r_d;
  logic [4:0]         rb_q, rb_d;
  logic [32:0]        term_q, term_d;
  logic signed [34:0] acc_q, acc_d;
  logic [3:0]         k_q, k_d;
  logic [31:0]        xk_q, xk_d;
  logic [31:0]        qe_q, qe_d;
  logic [31:0]        rr_q, rr_d;
  logic [5:0]         qexp_q, qexp_d;
  logic [63:0]        total_q, total_d;
  logic [31:0]        dens_q, dens_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [MulW-1:0]    mul_a, mul_b;
  logic [ProdW-1:0]   mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               st_we, st_re;
  logic [AddrW-1:0]   st_waddr, st_raddr;
  logic [31:0]        st_wdata, st_rdata;

  logic [31:0]        lim32, cnt32, idx32;
  logic [32:0]        cand;
  logic [47:0]        sum_mag;
  logic [63:0]        m2, var_v, sq_sum;
  logic [32:0]        d33, ad33;
  logic [34:0]        h7;
  logic [31:0]        krem;
  logic [32:0]        term_new;
  logic [32:0]        e_pos;
  logic [63:0]        ln2_sh;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegMaxObs);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxObs) ? {21'd0, maxobs_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxobs_q <= MaxObsReset;
    end else if (cfg_wr) begin
      maxobs_q <= pwdata[10:0];
    end
  end

  gke_store #(.Depth(StoreDepth), .AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  gke_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  gke_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign lim32 = (32'(maxobs_q) > 32'(StoreDepth)) ? 32'(StoreDepth) : 32'(maxobs_q);
  assign cnt32 = 32'(cnt_q);
  assign idx32 = 32'(idx_q);
  assign cand  = 33'({r_q | (25'd1 << rb_q)});
  assign sum_mag = sum_q[47] ? (48'd0 - 48'(sum_q)) : 48'(sum_q);
  assign m2    = 64'(mul_p[65:16]);
  assign var_v = (ex2_q > m2) ? (ex2_q - m2) : 64'd0;
  assign sq_sum = res_q + bit_q;
  assign d33   = {in_q.value[31], in_q.value} - {st_rdata[31], st_rdata};
  assign ad33  = d33[32] ? (33'd0 - d33) : d33;
  assign h7    = {width_q, 3'b000} - {3'b000, width_q};
  assign krem  = xk_q - mul_p[31:0];
  assign term_new = (krem >= {28'd0, k_q}) ? ({1'b0, qe_q} + 33'd1) : {1'b0, qe_q};
  assign e_pos = acc_q[34] ? 33'd0 : acc_q[32:0];
  assign ln2_sh = 64'(Ln2Q32) << rb_q;

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    half_d      = half_q;
    sum_d       = sum_q;
    sqsum_d     = sqsum_q;
    width_d     = width_q;
    mean_d      = mean_q;
    ex2_d       = ex2_q;
    rad_d       = rad_q;
    res_d       = res_q;
    bit_d       = bit_q;
    sigma_d     = sigma_q;
    r_d         = r_q;
    rb_d        = rb_q;
    term_d      = term_q;
    acc_d       = acc_q;
    k_d         = k_q;
    xk_d        = xk_q;
    qe_d        = qe_q;
    rr_d        = rr_q;
    qexp_d      = qexp_q;
    total_d     = total_q;
    dens_d      = dens_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_waddr    = '0;
    st_wdata    = '0;
    st_raddr    = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          dens_d  = '0;
          state_d = (in_data_i.operation == OpEval) ? StEvChk : StInsChk;
        end
      end
      StInsChk: begin
        if ((cnt32 > lim32) || ((cnt32 == lim32) && (cnt_q != '0))) begin
          half_d  = cnt_q >> 1;
          idx_d   = '0;
          sum_d   = '0;
          sqsum_d = '0;
          state_d = StHvRd;
        end else begin
          state_d = StApp;
        end
      end
      StHvRd: begin
        if (idx_q == half_q) begin
          cnt_d   = half_q;
          state_d = StInsChk;
        end else begin
          st_re    = 1'b1;
          st_raddr = AddrW'({idx32[30:0], 1'b1});
          state_d  = StHvDat;
        end
      end
      StHvDat: begin
        st_we    = 1'b1;
        st_waddr = idx_q[AddrW-1:0];
        st_wdata = st_rdata;
        sum_d    = sum_q + 48'(signed'(st_rdata));
        mul_a    = abs33(st_rdata);
        mul_b    = abs33(st_rdata);
        state_d  = StHvAcc;
      end
      StHvAcc: begin
        sqsum_d = sqsum_q + m2;
        idx_d   = idx_q + CntW'(1);
        state_d = StHvRd;
      end
      StApp: begin
        st_we    = 1'b1;
        st_waddr = cnt_q[AddrW-1:0];
        st_wdata = in_q.value;
        sum_d    = sum_q + 48'(in_q.value);
        mul_a    = abs33(in_q.value);
        mul_b    = abs33(in_q.value);
        state_d  = StAppAcc;
      end
      StAppAcc: begin
        sqsum_d = sqsum_q + m2;
        cnt_d   = cnt_q + CntW'(1);
        state_d = StMeanGo;
      end
      StMeanGo: begin
        div_req.start = 1'b1;
        div_req.steps = DivStepW'(48);
        div_req.num   = {sum_mag, 16'd0};
        div_req.den   = DivDenW'(cnt_q);
        state_d       = StMeanWait;
      end
      StMeanWait: begin
        if (!div_rsp.busy) begin
          mean_d  = sum_q[47] ? (32'd0 - div_rsp.quo[31:0]) : div_rsp.quo[31:0];
          state_d = StEx2Go;
        end
      end
      StEx2Go: begin
        div_req.start = 1'b1;
        div_req.steps = DivStepW'(64);
        div_req.num   = sqsum_q;
        div_req.den   = DivDenW'(cnt_q);
        state_d       = StEx2Wait;
      end
      StEx2Wait: begin
        if (!div_rsp.busy) begin
          ex2_d   = div_rsp.quo;
          state_d = StM2;
        end
      end
      StM2: begin
        mul_a   = abs33(mean_q);
        mul_b   = abs33(mean_q);
        state_d = StVar;
      end
      StVar: begin
        rad_d   = {var_v[47:0], 16'd0};
        res_d   = '0;
        bit_d   = 64'h4000_0000_0000_0000;
        state_d = StSqrt;
      end
      StSqrt: begin
        if (rad_q >= sq_sum) begin
          rad_d = rad_q - sq_sum;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          sigma_d = res_d[31:0];
          r_d     = '0;
          rb_d    = 5'd24;
          state_d = StRt1;
        end
      end
      StRt1: begin
        if (66'(cand) > Q24One) begin
          if (rb_q == 5'd0) begin
            state_d = StBw1;
          end else begin
            rb_d = rb_q - 5'd1;
          end
        end else begin
          mul_a   = cand;
          mul_b   = cand;
          state_d = StRt2;
        end
      end
      StRt2: begin
        mul_a   = 33'(mul_p[48:24]);
        mul_b   = 33'(mul_p[48:24]);
        state_d = StRt3;
      end
      StRt3: begin
        mul_a   = 33'(mul_p[48:24]);
        mul_b   = cand;
        state_d = StRt4;
      end
      StRt4: begin
        mul_a   = 33'(mul_p[48:24]);
        mul_b   = 33'(cnt_q);
        state_d = StRt5;
      end
      StRt5: begin
        if (mul_p <= Q24One) begin
          r_d = cand[24:0];
        end
        if (rb_q == 5'd0) begin
          state_d = StBw1;
        end else begin
          rb_d    = rb_q - 5'd1;
          state_d = StRt1;
        end
      end
      StBw1: begin
        mul_a   = {1'b0, sigma_q};
        mul_b   = 33'(r_q);
        state_d = StBw2;
      end
      StBw2: begin
        mul_a   = mul_p[56:24];
        mul_b   = NineTenthsQ24;
        state_d = StBw3;
      end
      StBw3: begin
        width_d = (mul_p[65:56] != '0) ? 32'hFFFF_FFFF : mul_p[55:24];
        state_d = StDone;
      end
      StEvChk: begin
        if ((cnt_q == '0) || (width_q == '0)) begin
          state_d = StDone;
        end else begin
          total_d = '0;
          idx_d   = '0;
          state_d = StEvRd;
        end
      end
      StEvRd: begin
        if (idx_q == cnt_q) begin
          state_d = StFin1;
        end else begin
          st_re    = 1'b1;
          st_raddr = idx_q[AddrW-1:0];
          state_d  = StEvDat;
        end
      end
      StEvDat: begin
        if ({2'b00, ad33} >= h7) begin
          idx_d   = idx_q + CntW'(1);
          state_d = StEvRd;
        end else begin
          div_req.start = 1'b1;
          div_req.steps = DivStepW'(48);
          div_req.num   = {ad33[31:0], 32'd0};
          div_req.den   = DivDenW'(width_q);
          state_d       = StEvU;
        end
      end
      StEvU: begin
        if (!div_rsp.busy) begin
          mul_a   = 33'(div_rsp.quo[18:0]);
          mul_b   = 33'(div_rsp.quo[18:0]);
          state_d = StEvT;
        end
      end
      StEvT: begin
        rad_d   = 64'({mul_p[37:17], 16'd0});
        qexp_d  = '0;
        rb_d    = 5'd5;
        state_d = StEvQ;
      end
      StEvQ: begin
        if (rad_q >= ln2_sh) begin
          rad_d  = rad_q - ln2_sh;
          qexp_d = qexp_q | (6'd1 << rb_q);
        end
        if (rb_q == 5'd0) begin
          rr_d    = rad_d[31:0];
          term_d  = 33'h1_0000_0000;
          acc_d   = 35'sh1_0000_0000;
          k_d     = 4'd1;
          state_d = StK1;
        end else begin
          rb_d = rb_q - 5'd1;
        end
      end
      StK1: begin
        mul_a   = term_q;
        mul_b   = {1'b0, rr_q};
        state_d = StK2;
      end
      StK2: begin
        xk_d    = mul_p[63:32];
        mul_a   = {1'b0, mul_p[63:32]};
        mul_b   = recip_q32(k_q);
        state_d = StK3;
      end
      StK3: begin
        qe_d    = mul_p[63:32];
        mul_a   = {1'b0, mul_p[63:32]};
        mul_b   = 33'(k_q);
        state_d = StK4;
      end
      StK4: begin
        term_d = term_new;
        acc_d  = k_q[0] ? (acc_q - signed'({2'b00, term_new}))
                        : (acc_q + signed'({2'b00, term_new}));
        if (k_q == TaylorTerms) begin
          state_d = StPhi;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = StK1;
        end
      end
      StPhi: begin
        mul_a   = e_pos >> qexp_q;
        mul_b   = InvSqrt2PiQ32;
        state_d = StEvAcc;
      end
      StEvAcc: begin
        total_d = total_q + 64'(mul_p[65:32]);
        idx_d   = idx_q + CntW'(1);
        state_d = StEvRd;
      end
      StFin1: begin
        mul_a   = 33'(cnt_q);
        mul_b   = {1'b0, width_q};
        state_d = StFin2;
      end
      StFin2: begin
        div_req.start = 1'b1;
        div_req.steps = DivStepW'(64);
        div_req.num   = {total_q[55:0], 8'd0};
        div_req.den   = mul_p[DivDenW-1:0];
        state_d       = StFin3;
      end
      StFin3: begin
        if (!div_rsp.busy) begin
          dens_d  = (div_rsp.quo[63:32] != '0) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.density_out   = dens_q;
          out_d.bandwidth_out = width_q;
          out_d.mean_out      = mean_q;
          out_d.sample_count  = cnt32[10:0];
          state_d             = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      sum_q       <= '0;
      sqsum_q     <= '0;
      width_q     <= '0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      sqsum_q     <= sqsum_d;
      width_q     <= width_d;
      mean_q      <= mean_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    idx_q   <= idx_d;
    half_q  <= half_d;
    ex2_q   <= ex2_d;
    rad_q   <= rad_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    sigma_q <= sigma_d;
    r_q     <= r_d;
    rb_q    <= rb_d;
    term_q  <= term_d;
    acc_q   <= acc_d;
    k_q     <= k_d;
    xk_q    <= xk_d;
    qe_q    <= qe_d;
    rr_q    <= rr_d;
    qexp_q  <= qexp_d;
    total_q <= total_d;
    dens_q  <= dens_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/gke_checker.sv */
`timescale 1ns / 1ps
module gke_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input gke_pkg::in_item_t            in_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input gke_pkg::out_item_t           out_data_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [gke_pkg::CfgAddrW-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);

  // hold result until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new transaction taken while one is in progress");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.sample_count == 11'd0) |->
      (out_data_o.bandwidth_out == 32'd0) && (out_data_o.mean_out == 32'sd0) &&
      (out_data_o.density_out == 32'd0))
    else $error("empty store reports nonzero statistics");

  a_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.bandwidth_out == 32'd0) |->
      out_data_o.density_out == 32'd0)
    else $error("density without bandwidth");

endmodule

bind gaussian_kde_estimator gke_checker u_gke_checker (.*);
